FILE: sv/mma_pkg.sv
// shared types and constants for the multichannel moving average
package mma_pkg;

    localparam int READING_W = 10;
    localparam int QCH_W     = 3;
    localparam int SELECT_W  = 3;

    // the mux select is masked to four bits before it is cut to the port width
    localparam logic [3:0] SELECT_MASK = 4'hF;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    // status that travels with a window sum to the output stage
    typedef struct packed
    {
        logic                start_conversion;
        logic [SELECT_W-1:0] next_channel;
    } res_ctrl_t;

endpackage

FILE: sv/mma_window.sv
// channel pointers, sample ring memory and per-channel window sums
module mma_window #(
    parameter int CHANNELS = 6,
    parameter int WINDOW   = 16,
    parameter int SUM_W    = 14,
    parameter int CH_W     = 3,
    parameter int PW       = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  mma_pkg::op_t               in_op,
    input  logic [mma_pkg::READING_W-1:0] in_reading,
    input  logic [mma_pkg::QCH_W-1:0]  in_qch,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [SUM_W-1:0]           out_sum,
    output mma_pkg::res_ctrl_t         out_ctrl
);
    import mma_pkg::*;

    localparam int ADDR_W = CH_W + PW;
    localparam int DEPTH  = CHANNELS * (2 ** PW);
    localparam int QW     = CH_W + QCH_W;

    // pointer state, updated when a sample is accepted; window sums follow in the sum stage
    logic [CH_W-1:0]  cur_ch_reg;
    logic [PW-1:0]    pos_reg     [CHANNELS];
    logic             wrapped_reg [CHANNELS];
    logic [SUM_W-1:0] sum_reg     [CHANNELS];

    logic [READING_W-1:0] mem [0:DEPTH-1];

    // first stage
    logic                 s1_valid_reg;
    op_t                  s1_op_reg;
    logic [READING_W-1:0] s1_reading_reg;
    logic [QCH_W-1:0]     s1_qch_reg;
    logic [CH_W-1:0]      s1_ch_reg;
    logic [PW-1:0]        s1_pos_reg;
    logic                 s1_old_ok_reg;
    logic [SELECT_W-1:0]  s1_next_reg;
    logic [READING_W-1:0] s1_old_reg;

    // sum stage
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;
    res_ctrl_t        out_ctrl_reg;

    logic                 in_fire;
    logic                 s1_adv;
    logic [CH_W-1:0]      ch_inc;
    logic [PW-1:0]        pos_cur;
    logic [PW-1:0]        pos_inc;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 fwd;
    logic [3:0]           sel_wide;
    logic [SELECT_W-1:0]  sel_next;
    logic [QW-1:0]        qch_wide;
    logic                 q_in_range;
    logic [CH_W-1:0]      q_idx;
    logic [READING_W-1:0] old_val;
    logic [SUM_W-1:0]     new_sum;
    logic [SUM_W-1:0]     res_sum;

    always_comb
    begin
        s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready = !s1_valid_reg || s1_adv;
        in_fire  = in_valid && in_ready;

        if (cur_ch_reg == CH_W'(CHANNELS - 1))
            ch_inc = '0;
        else
            ch_inc = cur_ch_reg + CH_W'(1);

        pos_cur = pos_reg[cur_ch_reg];
        if (pos_cur == PW'(WINDOW - 1))
            pos_inc = '0;
        else
            pos_inc = pos_cur + PW'(1);

        rd_addr = {cur_ch_reg, pos_cur};
        wr_addr = {s1_ch_reg, s1_pos_reg};
        // only when one ring slot is reused by back-to-back samples
        fwd = s1_valid_reg && (s1_op_reg == OP_SAMPLE) && (wr_addr == rd_addr);

        if (in_op == OP_SAMPLE)
            sel_wide = 4'(ch_inc) & SELECT_MASK;
        else
            sel_wide = 4'(cur_ch_reg) & SELECT_MASK;
        sel_next = sel_wide[SELECT_W-1:0];

        qch_wide   = QW'(s1_qch_reg);
        q_in_range = qch_wide < QW'(CHANNELS);
        q_idx      = qch_wide[CH_W-1:0];

        old_val = s1_old_ok_reg ? s1_old_reg : '0;
        new_sum = sum_reg[s1_ch_reg] - SUM_W'(old_val) + SUM_W'(s1_reading_reg);

        if (s1_op_reg == OP_SAMPLE)
            res_sum = new_sum;
        else if (q_in_range)
            res_sum = sum_reg[q_idx];
        else
            res_sum = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_ch_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]     <= '0;
                wrapped_reg[i] <= 1'b0;
                sum_reg[i]     <= '0;
            end
        end
        else
        begin
            if (in_fire && in_op == OP_SAMPLE)
            begin
                cur_ch_reg          <= ch_inc;
                pos_reg[cur_ch_reg] <= pos_inc;
                if (pos_cur == PW'(WINDOW - 1))
                    wrapped_reg[cur_ch_reg] <= 1'b1;
            end

            if (s1_adv && s1_op_reg == OP_SAMPLE)
                sum_reg[s1_ch_reg] <= new_sum;

            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg      <= in_op;
            s1_reading_reg <= in_reading;
            s1_qch_reg     <= in_qch;
            s1_ch_reg      <= cur_ch_reg;
            s1_pos_reg     <= pos_cur;
            s1_old_ok_reg  <= wrapped_reg[cur_ch_reg];
            s1_next_reg    <= sel_next;
            s1_old_reg     <= fwd ? s1_reading_reg : mem[rd_addr];
        end
        if (s1_adv && s1_op_reg == OP_SAMPLE)
            mem[wr_addr] <= s1_reading_reg;
        if (s1_adv)
        begin
            out_sum_reg                   <= res_sum;
            out_ctrl_reg.start_conversion <= (s1_op_reg == OP_SAMPLE);
            out_ctrl_reg.next_channel     <= s1_next_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;
    assign out_ctrl  = out_ctrl_reg;

endmodule

FILE: sv/mma_divider.sv
// divides a window sum by the window length with a reciprocal multiply
module mma_divider #(
    parameter int WINDOW = 16,
    parameter int SUM_W  = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SUM_W-1:0]              in_sum,
    input  mma_pkg::res_ctrl_t            in_ctrl,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mma_pkg::READING_W-1:0] out_average,
    output mma_pkg::res_ctrl_t            out_ctrl
);
    import mma_pkg::*;

    // exact for every sum below 2**SUM_W
    localparam int L      = (WINDOW > 1) ? $clog2(WINDOW) : 0;
    localparam int SHIFT  = SUM_W + L;
    localparam int RECIP_W = SUM_W + 2;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int PROD_W = SUM_W + RECIP_W;

    logic                 out_valid_reg;
    logic [READING_W-1:0] avg_reg;
    res_ctrl_t            ctrl_reg;

    logic [PROD_W-1:0] product;
    logic              fire;

    always_comb
    begin
        in_ready = !out_valid_reg || out_ready;
        fire     = in_valid && in_ready;
        product  = PROD_W'(in_sum) * PROD_W'(RECIP_W'(RECIP));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            avg_reg  <= product[SHIFT +: READING_W];
            ctrl_reg <= in_ctrl;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_average = avg_reg;
    assign out_ctrl    = ctrl_reg;

endmodule

FILE: sv/multichannel_moving_average.sv
// Multichannel boxcar moving average with round-robin channel sampling.
//
// Input stream (s_axis): tuser is the item kind (0 sample, 1 query). A sample
// carries the converter reading of the current channel; a query names a
// channel in query_channel. Every item gives exactly one result item.
// Output stream (m_axis): the window average of the sampled or queried
// channel, the mux select of the channel to convert next, and in tuser the
// start strobe, high for results of sample items.
// Throughput is one item per clock while the receiver takes results. An
// accepted item passes three registers: the input register, loaded as it
// is accepted; the window-sum register (one subtract and one add on the
// ring memory's registered read); and the output register, loaded with the
// reciprocal multiply.
// Reset clears the channel pointer, ring positions and sums at once; ring
// slots never written read as zero through a per-channel wrap flag, so the
// early windows average in zeros and no clearing pass is needed.
// When the receiver stalls the result holds and the pipeline fills; tready
// drops only when all three stages hold items.
module multichannel_moving_average #(
    parameter int CHANNELS = 6,
    parameter int WINDOW   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // reading[9:0], query_channel[12:10], zeros
    input  logic [0:0]  s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // average[9:0], next_channel[12:10], zeros
    output logic [0:0]  m_axis_tuser    // start_conversion[0]
);
    import mma_pkg::*;

    localparam int SUM_W = $clog2(WINDOW * 1023 + 1);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    op_t                  in_op;
    logic                 sum_valid;
    logic                 sum_ready;
    logic [SUM_W-1:0]     sum_data;
    res_ctrl_t            sum_ctrl;
    logic [READING_W-1:0] average;
    res_ctrl_t            res_ctrl;

    assign in_op = op_t'(s_axis_tuser[0]);

    mma_window #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW),
        .SUM_W    (SUM_W),
        .CH_W     (CH_W),
        .PW       (PW)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (in_op),
        .in_reading (s_axis_tdata[9:0]),
        .in_qch     (s_axis_tdata[12:10]),
        .out_valid  (sum_valid),
        .out_ready  (sum_ready),
        .out_sum    (sum_data),
        .out_ctrl   (sum_ctrl)
    );

    mma_divider #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (sum_valid),
        .in_ready    (sum_ready),
        .in_sum      (sum_data),
        .in_ctrl     (sum_ctrl),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_average (average),
        .out_ctrl    (res_ctrl)
    );

    assign m_axis_tdata = {3'b000, res_ctrl.next_channel, average};
    assign m_axis_tuser = res_ctrl.start_conversion;

endmodule

FILE: sv/mma_checker.sv
// port-level checks for the multichannel moving average, bound to the top level
module mma_checker #(
    parameter int CHANNELS = 6
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);
    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a free output leaves no stage full, so input is never blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output is free");

    // while CHANNELS is at most 8, the mux select names an existing channel
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[12:10]) < CHANNELS
                           || CHANNELS > 8))
        else $error("next channel out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:13] == 3'b000)
        else $error("padding bits set");

endmodule

bind multichannel_moving_average mma_checker #(.CHANNELS(CHANNELS)) u_mma_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/testbench.sv
// self-checking testbench for the multichannel moving average
`timescale 1ns / 1ps

module testbench;

    import mma_pkg::*;

    localparam int NUM_CH      = 6;
    localparam int WIN_LEN     = 16;
    localparam int RAND_ITEMS  = 1720;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed
    {
        logic [9:0] average;
        logic [2:0] next_channel;
        logic       start_conversion;
    } avg_result_t;

    typedef struct packed
    {
        op_t         op;
        logic [9:0]  reading;
        logic [2:0]  query_channel;
        logic        typed;
        avg_result_t result;
    } stim_row_t;

    // directed items; rows with typed set carry a hand-worked result
    localparam int DIR_ROWS = 21;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{OP_QUERY,  10'd0,    3'd0, 1'b1, '{10'd0,  3'd0, 1'b0}},
        '{OP_QUERY,  10'd1023, 3'd5, 1'b1, '{10'd0,  3'd0, 1'b0}},
        '{OP_QUERY,  10'd0,    3'd6, 1'b1, '{10'd0,  3'd0, 1'b0}},
        '{OP_QUERY,  10'd1023, 3'd7, 1'b1, '{10'd0,  3'd0, 1'b0}},
        '{OP_SAMPLE, 10'd1023, 3'd7, 1'b1, '{10'd63, 3'd1, 1'b1}},
        '{OP_SAMPLE, 10'd0,    3'd0, 1'b1, '{10'd0,  3'd2, 1'b1}},
        '{OP_SAMPLE, 10'd1023, 3'd0, 1'b1, '{10'd63, 3'd3, 1'b1}},
        '{OP_SAMPLE, 10'd512,  3'd0, 1'b1, '{10'd32, 3'd4, 1'b1}},
        '{OP_SAMPLE, 10'd15,   3'd0, 1'b1, '{10'd0,  3'd5, 1'b1}},
        '{OP_SAMPLE, 10'd16,   3'd0, 1'b1, '{10'd1,  3'd0, 1'b1}},
        '{OP_QUERY,  10'd0,    3'd0, 1'b1, '{10'd63, 3'd0, 1'b0}},
        '{OP_QUERY,  10'd0,    3'd3, 1'b1, '{10'd32, 3'd0, 1'b0}},
        '{OP_QUERY,  10'd0,    3'd6, 1'b1, '{10'd0,  3'd0, 1'b0}},
        '{OP_SAMPLE, 10'd1023, 3'd0, 1'b0, '0},
        '{OP_SAMPLE, 10'd1023, 3'd0, 1'b0, '0},
        '{OP_SAMPLE, 10'd682,  3'd0, 1'b0, '0},
        '{OP_SAMPLE, 10'd341,  3'd0, 1'b0, '0},
        '{OP_QUERY,  10'd0,    3'd1, 1'b0, '0},
        '{OP_QUERY,  10'd0,    3'd2, 1'b0, '0},
        '{OP_QUERY,  10'd0,    3'd4, 1'b0, '0},
        '{OP_SAMPLE, 10'd0,    3'd0, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;   // reading[9:0], query_channel[12:10], zeros
    logic [0:0]  s_axis_tuser   = '0;   // op[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;          // average[9:0], next_channel[12:10], zeros
    logic [0:0]  m_axis_tuser;          // start_conversion[0]

    // predictor state
    int window_hist [NUM_CH][WIN_LEN];
    int window_total [NUM_CH];
    int ring_idx [NUM_CH];
    int mux_channel;

    avg_result_t expected_averages [$];

    int send_idle_pct;
    int stall_pct;
    int error_count;
    int readings_sent;
    int query_count;
    int bad_query_count;
    int peak_average;
    int idle_cycles;

    multichannel_moving_average #(
        .CHANNELS (NUM_CH),
        .WINDOW   (WIN_LEN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // advance the window state by one item and return its result
    function automatic avg_result_t average_after_item(op_t op, logic [9:0] reading,
                                                      logic [2:0] qch);
        avg_result_t res;
        int ch;
        if (op == OP_SAMPLE)
        begin
            ch = mux_channel;
            window_total[ch] = window_total[ch] - window_hist[ch][ring_idx[ch]] + reading;
            window_hist[ch][ring_idx[ch]] = reading;
            ring_idx[ch] = (ring_idx[ch] + 1) % WIN_LEN;
            mux_channel = (ch + 1) % NUM_CH;
            res.average = 10'(window_total[ch] / WIN_LEN);
            res.start_conversion = 1'b1;
        end
        else
        begin
            res.average = (qch < NUM_CH) ? 10'(window_total[qch] / WIN_LEN) : 10'd0;
            res.start_conversion = 1'b0;
        end
        res.next_channel = 3'(mux_channel);
        return res;
    endfunction

    // mostly uniform, with the range ends weighted up
    function automatic logic [9:0] pick_reading();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 10'd0;
        if (roll < 16)
            return 10'h3FF;
        return 10'($urandom);
    endfunction

    task automatic send_item(input op_t op, input logic [9:0] reading,
                             input logic [2:0] qch, input logic typed,
                             input avg_result_t typed_res);
        avg_result_t res;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, qch, reading};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = average_after_item(op, reading, qch);
        if (typed)
            res = typed_res;
        expected_averages.push_back(res);
        if (res.average > peak_average)
            peak_average = res.average;
        if (op == OP_SAMPLE)
            readings_sent++;
        else
            query_count++;
        if (op == OP_QUERY && qch >= NUM_CH)
            bad_query_count++;
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_averages.size() != 0);
    endtask

    task automatic run_phase(input int budget);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            kind = $urandom_range(99);
            len  = 0;
            if (kind < 5)
            begin
                // fill every window with full scale, then read them all back
                len = NUM_CH * WIN_LEN + $urandom_range(NUM_CH);
                repeat (len)
                    send_item(OP_SAMPLE, 10'h3FF, 3'($urandom), 1'b0, '0);
                for (int c = 0; c < 8; c++)
                    send_item(OP_QUERY, 10'($urandom), 3'(c), 1'b0, '0);
                len += 8;
            end
            else if (kind < 10)
            begin
                len = NUM_CH * WIN_LEN + $urandom_range(NUM_CH);
                repeat (len)
                    send_item(OP_SAMPLE, 10'd0, 3'($urandom), 1'b0, '0);
            end
            else if (kind < 70)
            begin
                // converter stream with queries mixed in
                len = $urandom_range(40, 1);
                repeat (len)
                begin
                    if ($urandom_range(99) < 15)
                        send_item(OP_QUERY, 10'($urandom),
                                  3'($urandom_range(NUM_CH - 1)), 1'b0, '0);
                    else
                        send_item(OP_SAMPLE, pick_reading(), 3'($urandom), 1'b0, '0);
                end
            end
            else
            begin
                len = $urandom_range(8, 1);
                repeat (len)
                    send_item(op_t'($urandom_range(1)), 10'($urandom), 3'($urandom),
                              1'b0, '0);
            end
            sent += len;
        end
    endtask

    // result checker, receiver stalls and watchdog
    always @(posedge clk)
    begin
        avg_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_averages.size() == 0)
            begin
                $display("%0t: result with none expected: average %0d next %0d start %0d",
                         $time, m_axis_tdata[9:0], m_axis_tdata[12:10], m_axis_tuser[0]);
                error_count++;
            end
            else
            begin
                want = expected_averages.pop_front();
                if (m_axis_tdata[9:0] !== want.average)
                begin
                    $display("%0t: average expected %0d, got %0d",
                             $time, want.average, m_axis_tdata[9:0]);
                    error_count++;
                end
                if (m_axis_tdata[12:10] !== want.next_channel)
                begin
                    $display("%0t: next_channel expected %0d, got %0d",
                             $time, want.next_channel, m_axis_tdata[12:10]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.start_conversion)
                begin
                    $display("%0t: start_conversion expected %0d, got %0d",
                             $time, want.start_conversion, m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].op, DIRECTED[i].reading, DIRECTED[i].query_channel,
                      DIRECTED[i].typed, DIRECTED[i].result);
        drain_results();

        run_phase(RAND_ITEMS / 4);
        drain_results();

        send_idle_pct = 55;
        run_phase(RAND_ITEMS / 4);
        drain_results();

        send_idle_pct = 0;
        stall_pct     = 55;
        run_phase(RAND_ITEMS / 4);
        drain_results();

        send_idle_pct = 38;
        stall_pct     = 38;
        run_phase(RAND_ITEMS / 4);
        s_axis_tvalid <= 1'b0;

        while (expected_averages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d samples and %0d queries (%0d on absent channels)",
                 readings_sent, query_count, bad_query_count);
        $display("under four handshake pressure mixes, peak average %0d", peak_average);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/mma_pkg.sv
sv/mma_window.sv
sv/mma_divider.sv
sv/multichannel_moving_average.sv
sv/mma_checker.sv
tb/testbench.sv
